>>> hdl/stick_direction_autorepeat_unit_assert.svh
// Assertion macros shared by the stick direction auto-repeat RTL.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef STICK_DIRECTION_AUTOREPEAT_UNIT_ASSERT_SVH
`define STICK_DIRECTION_AUTOREPEAT_UNIT_ASSERT_SVH

// A property that is checked on every clock edge outside reset.
`define SDA_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// An implication that is checked on every clock edge outside reset.
`define SDA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hdl/sda_pkg.sv
// Shared types and constants for the stick direction auto-repeat unit.
// No dependencies; every other RTL file refers to this package by scoped names.
`default_nettype none

package sda_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 4;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_DEAD_ZONE     = 2'd0;
    localparam logic [1:0] REG_FIRST_DELAY   = 2'd1;
    localparam logic [1:0] REG_REPEAT_PERIOD = 2'd2;

    localparam logic [6:0] DEAD_ZONE_RST     = 7'd40;
    localparam logic [7:0] FIRST_DELAY_RST   = 8'd30;
    localparam logic [7:0] REPEAT_PERIOD_RST = 8'd5;

    // Bit positions inside a direction mask.
    localparam int unsigned DIR_RIGHT = 0;
    localparam int unsigned DIR_LEFT  = 1;
    localparam int unsigned DIR_DOWN  = 2;
    localparam int unsigned DIR_UP    = 3;

    typedef logic [3:0] dirs_t;

    typedef struct packed {
        logic signed [7:0] stick_x;
        logic signed [7:0] stick_y;
        logic              rearm;
    } sample_t;

    typedef struct packed {
        dirs_t held_dirs;
        dirs_t tapped_dirs;
        dirs_t repeat_dirs;
        logic  active;
    } result_t;

    typedef struct packed {
        logic [6:0] dead_zone;
        logic [7:0] first_delay;
        logic [7:0] repeat_period;
    } cfg_t;

endpackage

`default_nettype wire

>>> hdl/sda_cfg_regs.sv
// Configuration register file behind the APB-style port.
// Depends on sda_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module sda_cfg_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sda_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [sda_pkg::DATA_W-1:0]  pwdata,
    output logic      [sda_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output sda_pkg::cfg_t                    cfg
);

    logic [6:0] dead_zone_reg;
    logic [7:0] first_delay_reg;
    logic [7:0] repeat_period_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg     <= sda_pkg::DEAD_ZONE_RST;
            first_delay_reg   <= sda_pkg::FIRST_DELAY_RST;
            repeat_period_reg <= sda_pkg::REPEAT_PERIOD_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                sda_pkg::REG_DEAD_ZONE:     dead_zone_reg     <= pwdata[6:0];
                sda_pkg::REG_FIRST_DELAY:   first_delay_reg   <= pwdata[7:0];
                sda_pkg::REG_REPEAT_PERIOD: repeat_period_reg <= pwdata[7:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            sda_pkg::REG_DEAD_ZONE:     prdata = {25'd0, dead_zone_reg};
            sda_pkg::REG_FIRST_DELAY:   prdata = {24'd0, first_delay_reg};
            sda_pkg::REG_REPEAT_PERIOD: prdata = {24'd0, repeat_period_reg};
            default:                    prdata = '0;
        endcase
    end

    assign cfg.dead_zone     = dead_zone_reg;
    assign cfg.first_delay   = first_delay_reg;
    assign cfg.repeat_period = repeat_period_reg;

endmodule

`default_nettype wire

>>> hdl/sda_dir_classify.sv
// Threshold compare that turns one stick sample into a direction mask.
// Depends on sda_pkg for the direction bit positions and dirs_t.
`default_nettype none

module sda_dir_classify (
    input  wire logic signed [7:0] stick_x,
    input  wire logic signed [7:0] stick_y,
    input  wire logic        [6:0] dead_zone,
    output sda_pkg::dirs_t         dirs
);

    logic signed [8:0] pos_thr;
    logic signed [8:0] neg_thr;
    logic signed [8:0] x_ext;
    logic signed [8:0] y_ext;

    // Nine bits hold both the sample and the negated threshold without overflow.
    assign pos_thr = $signed({2'b00, dead_zone});
    assign neg_thr = -pos_thr;
    assign x_ext   = {stick_x[7], stick_x};
    assign y_ext   = {stick_y[7], stick_y};

    always_comb
    begin
        dirs                     = '0;
        dirs[sda_pkg::DIR_RIGHT] = x_ext > pos_thr;
        dirs[sda_pkg::DIR_LEFT]  = x_ext < neg_thr;
        dirs[sda_pkg::DIR_DOWN]  = y_ext < neg_thr;
        dirs[sda_pkg::DIR_UP]    = y_ext > pos_thr;
    end

endmodule

`default_nettype wire

>>> hdl/sda_core.sv
// Input register, frame state update and result register of the unit.
// Depends on sda_pkg and on sda_dir_classify.
`default_nettype none

module sda_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire sda_pkg::cfg_t    cfg,
    input  wire logic             sample_valid,
    output logic                  sample_stall,
    input  wire sda_pkg::sample_t sample,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output sda_pkg::result_t      result
);

    logic             s1_valid_reg;
    logic             s1_valid_next;
    sda_pkg::sample_t s1_data_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    sda_pkg::result_t out_data_reg;
    sda_pkg::result_t out_data_next;

    logic             enabled_reg;
    logic             enabled_next;
    sda_pkg::dirs_t   last_dirs_reg;
    sda_pkg::dirs_t   last_dirs_next;
    sda_pkg::dirs_t   tap_reg;
    sda_pkg::dirs_t   tap_next;
    sda_pkg::dirs_t   repeat_reg;
    sda_pkg::dirs_t   repeat_next;
    logic [7:0]       wait_count_reg;
    logic [7:0]       wait_count_next;

    sda_pkg::dirs_t   dirs;
    sda_pkg::dirs_t   diff;
    logic             out_free;
    logic             advance;
    logic             accept;
    logic             act;

    assign out_free     = !out_valid_reg || !result_stall;
    assign advance      = s1_valid_reg && out_free;
    assign sample_stall = s1_valid_reg && !out_free;
    assign accept       = sample_valid && !sample_stall;

    assign s1_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_free ? 1'b0 : out_valid_reg);

    sda_dir_classify u_classify (
        .stick_x   (s1_data_reg.stick_x),
        .stick_y   (s1_data_reg.stick_y),
        .dead_zone (cfg.dead_zone),
        .dirs      (dirs)
    );

    assign diff = dirs ^ last_dirs_reg;

    // One frame of the typematic state machine; state only moves on advance.
    always_comb
    begin
        enabled_next    = enabled_reg;
        last_dirs_next  = last_dirs_reg;
        tap_next        = tap_reg;
        repeat_next     = repeat_reg;
        wait_count_next = wait_count_reg;
        act             = 1'b0;
        if (s1_data_reg.rearm)
        begin
            enabled_next = 1'b0;
        end
        else if (!enabled_reg)
        begin
            if (dirs == '0)
            begin
                enabled_next = 1'b1;
            end
        end
        else
        begin
            act            = 1'b1;
            tap_next       = diff & dirs;
            last_dirs_next = dirs;
            if (diff != '0)
            begin
                repeat_next     = diff & dirs;
                wait_count_next = cfg.first_delay;
            end
            else if (wait_count_reg > 8'd1)
            begin
                repeat_next     = '0;
                wait_count_next = wait_count_reg - 8'd1;
            end
            else
            begin
                repeat_next     = dirs;
                wait_count_next = cfg.repeat_period;
            end
        end
    end

    always_comb
    begin
        out_data_next.held_dirs   = dirs;
        out_data_next.tapped_dirs = tap_next;
        out_data_next.repeat_dirs = repeat_next;
        out_data_next.active      = act;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            enabled_reg    <= 1'b0;
            last_dirs_reg  <= '0;
            tap_reg        <= '0;
            repeat_reg     <= '0;
            wait_count_reg <= sda_pkg::FIRST_DELAY_RST;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                enabled_reg    <= enabled_next;
                last_dirs_reg  <= last_dirs_next;
                tap_reg        <= tap_next;
                repeat_reg     <= repeat_next;
                wait_count_reg <= wait_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_data_reg <= sample;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

`default_nettype wire

>>> hdl/stick_direction_autorepeat_unit.sv
// Top level of the stick direction auto-repeat unit.
// Depends on sda_pkg, sda_cfg_regs, sda_core and the assertion macro header.
//
//  Channel   Direction  Handshake                  Payload
//  sample    in         sample_valid/sample_stall  sda_pkg::sample_t (x, y, rearm)
//  result    out        result_valid/result_stall  sda_pkg::result_t (held, tap, repeat, active)
//  config    in         psel/penable/pwrite/pready registers at 0x0, 0x4, 0x8
//
// A sample is registered on acceptance and its result is registered when the result register is free,
// so one sample is taken every cycle unless a stalled result fills the input and result registers.
// Reset clears the pipeline valids and the frame state and loads the register defaults.
// A stalled result holds its register; the input register then fills and stalls the input.
`default_nettype none

module stick_direction_autorepeat_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        sample_valid,
    output logic                             sample_stall,
    input  wire sda_pkg::sample_t            sample,
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output sda_pkg::result_t                 result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sda_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [sda_pkg::DATA_W-1:0]  pwdata,
    output logic      [sda_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);

    sda_pkg::cfg_t cfg;

    sda_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sda_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

`include "stick_direction_autorepeat_unit_assert.svh"

    // Strict thresholds never set both directions of one axis.
    `SDA_ASSERT_IMPLIES(a_no_opposite, result_valid,
        !(result.held_dirs[sda_pkg::DIR_RIGHT] && result.held_dirs[sda_pkg::DIR_LEFT]) &&
        !(result.held_dirs[sda_pkg::DIR_UP] && result.held_dirs[sda_pkg::DIR_DOWN]),
        "opposite directions set together")

    // On an active frame a tap is always a direction that is held now.
    `SDA_ASSERT_IMPLIES(a_tap_held, result_valid && result.active,
        (result.tapped_dirs & ~result.held_dirs) == 4'd0, "tap outside held mask")

    // On an active frame a repeat is always a direction that is held now.
    `SDA_ASSERT_IMPLIES(a_repeat_held, result_valid && result.active,
        (result.repeat_dirs & ~result.held_dirs) == 4'd0, "repeat outside held mask")

    // A full input register is only stalled while the result register is stalled.
    `SDA_ASSERT_ALWAYS(a_stall_cause, !sample_stall || (result_valid && result_stall),
        "input stalled without a stalled result")

endmodule

`default_nettype wire
